// ===== hw/rtl/generational_slot_handle_table_top_assert.svh =====
// Assertion macros shared by the handle table checker.
`ifndef GENERATIONAL_SLOT_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_SLOT_HANDLE_TABLE_TOP_ASSERT_SVH

// Property sampled on the rising clock edge and ignored while reset is high.
`define GSHT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gsht checker: property failed");

// Property sampled on the rising clock edge that also holds through reset.
`define GSHT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("gsht checker: property failed");

`endif

// ===== hw/rtl/gsht_pkg.sv =====
// Shared types and constants of the generational slot handle table.
`default_nettype none

package gsht_pkg;

   localparam int HANDLE_W = 31;
   localparam int SLOT_W   = 10;
   localparam int SWITCH_W = 32;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_RUN    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFREE = 2'd1,
      ST_BAD    = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/generational_slot_handle_table_top.sv =====
// A request's result is registered when EXEC writes back; an alloc with free slots passes POP first.
// Such an alloc reads the free stack first, then does one read-modify-write of the slot memory.
// One request is in flight at a time, so a new request is taken only after the last one writes back.
// The result register lets the next request transfer while a result is still stalled.
// Reset is synchronous: it empties the result register, clears the current slot and
// restores the free stack and slot tags by fill marks, so no clearing sweep is needed.
`default_nettype none

module generational_slot_handle_table_top #(
   parameter int SLOTS     = 1024,
   parameter int GEN_SHIFT = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gsht_pkg::op_type                  req_op,
   input  logic [gsht_pkg::HANDLE_W-1:0]     req_handle,
   input  logic [gsht_pkg::HANDLE_W-1:0]     req_parent_handle,
   input  logic                              req_check_perm,
   input  logic [gsht_pkg::SLOT_W-1:0]       req_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gsht_pkg::status_type              rsp_status,
   output logic                              rsp_found,
   output logic [gsht_pkg::HANDLE_W-1:0]     rsp_out_handle,
   output logic [gsht_pkg::SLOT_W-1:0]       rsp_out_slot
);
   import gsht_pkg::*;

   // Index width of a slot, and width of a count that can hold SLOTS itself.
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [31:0]   IDX_MASK = 32'(SLOTS - 1);
   localparam logic [31:0]   GEN_ONE  = 32'd1 << GEN_SHIFT;
   localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

   // One-hot sequencer: IDLE takes a request, POP turns the free stack top into a
   // slot index for alloc, EXEC modifies and writes back the slot entry.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   // One slot memory word: everything an operation needs about a slot is read
   // and written back together.
   typedef struct packed {
      logic                busy;
      logic [HANDLE_W-1:0] tag;
      logic [HANDLE_W-1:0] owner;
      logic [SWITCH_W-1:0] switches;
   } slot_entry_type;

   // The new generation lies above the index bits. When it would wrap to zero or
   // turn negative as a 32-bit signed value, it restarts at the first generation.
   function automatic logic [HANDLE_W-1:0] next_tag(logic [HANDLE_W-1:0] tag,
                                                   logic [SW-1:0] idx);
      logic [31:0] t;
      t = (32'(tag) + GEN_ONE) & ~IDX_MASK;
      if (t == 32'd0 || t[31]) begin
         t = GEN_ONE;
      end
      t = t | 32'(idx);
      return t[HANDLE_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] to_out_slot(logic [SW-1:0] idx);
      logic [31:0] w;
      w = 32'(idx);
      return w[SLOT_W-1:0];
   endfunction

   // Memories.
   slot_entry_type slot_mem [SLOTS];
   logic [SW-1:0]  stack_mem [SLOTS];

   // Sequencer and table state.
   state_type          state_ff, state_in;
   logic [CW-1:0]      fc_ff, fc_in;
   // Lowest free count ever reached. Stack positions below it still hold their
   // reset contents, and exactly SLOTS minus this many slots were ever handed out;
   // every other slot still has tag zero and is free.
   logic [CW-1:0]      lowmark_ff, lowmark_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [SW-1:0]      cur_slot_ff, cur_slot_in;
   // The current slot's tag is held here. A current slot is always busy, and a
   // busy slot's tag cannot change, so the copy never goes stale.
   logic [HANDLE_W-1:0] cur_tag_ff, cur_tag_in;

   // Captured request.
   op_type              op_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [HANDLE_W-1:0] parent_ff;
   logic                perm_ff;
   logic                hzero_ff;
   logic                empty_ff;
   logic [SW-1:0]       sidx_ff;
   logic                known_ff;

   // Memory read data and write controls.
   slot_entry_type slot_rd_ff;
   slot_entry_type slot_wdata;
   logic [SW-1:0]  stack_rd_ff;
   logic           slot_rd_en, slot_we, stack_rd_en, stack_we;

   // Result register.
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic                rsp_found_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   status_type          res_status;
   logic                res_found;
   logic [HANDLE_W-1:0] res_handle;
   logic [SLOT_W-1:0]   res_slot;

   // Address selection.
   logic          req_accept, exec_fire, empty_now;
   logic [31:0]   s_wide, h_masked;
   logic [SW-1:0] s_idx, h_idx, pop_idx, fresh_idx, sel_idx;
   logic          s_range, h_range, sel_range, sel_known;
   logic [CW-1:0] alloc_cnt, pos, fresh_val;
   logic          busy_e, cur_hit;
   logic [HANDLE_W-1:0] tag_e;

   // A new request is taken only between operations, so a slot entry is always
   // written back before the next request reads it and no forwarding is needed.
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   // The write-back waits while a finished result is still stalled at the output.
   assign exec_fire  = (state_ff == S_EXEC) && !(rsp_valid_ff && rsp_stall);
   assign empty_now  = (fc_ff == '0);

   assign s_wide   = 32'(req_slot);
   assign s_idx    = s_wide[SW-1:0];
   assign s_range  = s_wide < 32'(SLOTS);
   assign h_masked = 32'(req_handle) & IDX_MASK;
   assign h_idx    = h_masked[SW-1:0];
   assign h_range  = h_masked < 32'(SLOTS);

   assign alloc_cnt = SLOTS_C - lowmark_ff;
   // Top of the free stack; only read while the stack is not empty.
   assign pos       = fc_ff - CW'(1);
   assign fresh_val = SLOTS_C - CW'(1) - pos;
   assign fresh_idx = fresh_val[SW-1:0];
   assign pop_idx   = (pos < lowmark_ff) ? fresh_idx : stack_rd_ff;

   always_comb begin
      if (state_ff == S_POP) begin
         sel_idx   = pop_idx;
         sel_range = 1'b1;
      end else if (req_op == OP_LOOKUP) begin
         sel_idx   = h_idx;
         sel_range = h_range;
      end else begin
         sel_idx   = s_idx;
         sel_range = s_range;
      end
      sel_known = sel_range && (CW'(sel_idx) < alloc_cnt);
   end

   assign slot_rd_en  = (req_accept && req_op != OP_ALLOC) || (state_ff == S_POP);
   assign stack_rd_en = req_accept && req_op == OP_ALLOC && !empty_now;

   // A slot never handed out reads as free with tag zero, whatever the memory holds.
   assign busy_e  = known_ff && slot_rd_ff.busy;
   assign tag_e   = known_ff ? slot_rd_ff.tag : '0;
   assign cur_hit = cur_valid_ff && (cur_slot_ff == sidx_ff);

   always_comb begin
      state_in     = state_ff;
      fc_in        = fc_ff;
      lowmark_in   = lowmark_ff;
      cur_valid_in = cur_valid_ff;
      cur_slot_in  = cur_slot_ff;
      cur_tag_in   = cur_tag_ff;
      slot_we      = 1'b0;
      slot_wdata   = slot_rd_ff;
      stack_we     = 1'b0;
      res_status   = ST_OK;
      res_found    = 1'b0;
      res_handle   = '0;
      res_slot     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_op == OP_ALLOC && !empty_now) ? S_POP : S_EXEC;
            end
         end
         S_POP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (exec_fire) begin
         case (op_ff)
            OP_ALLOC: begin
               if (empty_ff) begin
                  res_status = ST_NOFREE;
               end else begin
                  slot_we             = 1'b1;
                  slot_wdata.busy     = 1'b1;
                  slot_wdata.tag      = next_tag(tag_e, sidx_ff);
                  slot_wdata.owner    = parent_ff;
                  slot_wdata.switches = '0;
                  fc_in               = pos;
                  if (pos < lowmark_ff) begin
                     lowmark_in = pos;
                  end
                  res_found  = 1'b1;
                  res_handle = next_tag(tag_e, sidx_ff);
                  res_slot   = to_out_slot(sidx_ff);
               end
            end
            OP_FREE: begin
               if (!busy_e || fc_ff >= SLOTS_C) begin
                  res_status = ST_BAD;
               end else begin
                  slot_we         = 1'b1;
                  slot_wdata.busy = 1'b0;
                  stack_we        = 1'b1;
                  fc_in           = fc_ff + CW'(1);
                  if (cur_hit) begin
                     cur_valid_in = 1'b0;
                  end
                  res_found  = 1'b1;
                  res_handle = tag_e;
                  res_slot   = to_out_slot(sidx_ff);
               end
            end
            OP_LOOKUP: begin
               if (hzero_ff) begin
                  // Handle zero names the current slot, if there is one.
                  if (cur_valid_ff) begin
                     res_found  = 1'b1;
                     res_handle = cur_tag_ff;
                     res_slot   = to_out_slot(cur_slot_ff);
                  end
               end else if (!busy_e || tag_e != handle_ff) begin
                  res_status = ST_BAD;
               end else if (perm_ff && !cur_valid_ff) begin
                  res_status = ST_BAD;
               end else if (perm_ff && sidx_ff != cur_slot_ff &&
                            slot_rd_ff.owner != cur_tag_ff) begin
                  res_status = ST_BAD;
               end else begin
                  res_found  = 1'b1;
                  res_handle = tag_e;
                  res_slot   = to_out_slot(sidx_ff);
               end
            end
            OP_RUN: begin
               if (!busy_e) begin
                  res_status = ST_BAD;
               end else begin
                  // The switch count only rises on a real change of current slot.
                  if (!cur_hit) begin
                     slot_we             = 1'b1;
                     slot_wdata.switches = slot_rd_ff.switches + SWITCH_W'(1);
                     cur_valid_in        = 1'b1;
                     cur_slot_in         = sidx_ff;
                     cur_tag_in          = tag_e;
                  end
                  res_found  = 1'b1;
                  res_handle = tag_e;
                  res_slot   = to_out_slot(sidx_ff);
               end
            end
            default: begin
               res_status = ST_BAD;
            end
         endcase
      end
   end

   // Slot memory: one read port, one write port, registered read data.
   always_ff @(posedge clock) begin
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[sel_idx];
      end
      if (slot_we) begin
         slot_mem[sidx_ff] <= slot_wdata;
      end
   end

   // Free stack memory: pops read the top, pushes write at the free count.
   always_ff @(posedge clock) begin
      if (stack_rd_en) begin
         stack_rd_ff <= stack_mem[pos[SW-1:0]];
      end
      if (stack_we) begin
         stack_mem[fc_ff[SW-1:0]] <= sidx_ff;
      end
   end

   // Request capture and selected slot.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_op;
         handle_ff <= req_handle;
         parent_ff <= req_parent_handle;
         perm_ff   <= req_check_perm;
         hzero_ff  <= (req_handle == '0);
         empty_ff  <= empty_now;
      end
      if (slot_rd_en) begin
         sidx_ff  <= sel_idx;
         known_ff <= sel_known;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fc_ff        <= SLOTS_C;
         lowmark_ff   <= SLOTS_C;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         cur_tag_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         lowmark_ff   <= lowmark_in;
         cur_valid_ff <= cur_valid_in;
         cur_slot_ff  <= cur_slot_in;
         cur_tag_ff   <= cur_tag_in;
      end
   end

   // Result register: filled by the write-back, emptied by a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= res_status;
         rsp_found_ff  <= res_found;
         rsp_handle_ff <= res_handle;
         rsp_slot_ff   <= res_slot;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_slot   = rsp_slot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gsht_checker.sv =====
// Port-level checker for the generational slot handle table, with its bind.
`default_nettype none

`include "generational_slot_handle_table_top_assert.svh"

module gsht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input gsht_pkg::status_type          rsp_status,
   input logic                          rsp_found,
   input logic [gsht_pkg::HANDLE_W-1:0] rsp_out_handle,
   input logic [gsht_pkg::SLOT_W-1:0]   rsp_out_slot
);
   import gsht_pkg::*;

   // A stalled result stays offered and unchanged.
   `GSHT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_out_handle) && $stable(rsp_out_slot))

   // A failed request returns no slot and all-zero payload.
   `GSHT_ASSERT(a_fail_clean, rsp_valid && rsp_status != ST_OK |-> !rsp_found && rsp_out_handle == '0 && rsp_out_slot == '0)

   // A returned slot always carries a live, non-zero handle.
   `GSHT_ASSERT(a_found_handle, rsp_valid && rsp_found |-> rsp_status == ST_OK && rsp_out_handle != '0)

   // Reset empties the result register.
   `GSHT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind generational_slot_handle_table_top gsht_checker u_gsht_checker (.*);

`default_nettype wire
